### rtl/core/cursor_overlay_blend_macros.svh
// ----------------------------------------------------------------------------
// Cursor overlay blend: assertion macros
// Short forms for the concurrent checks of the cursor overlay blend block.
// ----------------------------------------------------------------------------
`ifndef CURSOR_OVERLAY_BLEND_MACROS_SVH
`define CURSOR_OVERLAY_BLEND_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define COB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define COB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cob_pkg.sv
// ----------------------------------------------------------------------------
// Cursor overlay blend package
// Register indexes, item kinds, size defaults and the blend arithmetic.
// ----------------------------------------------------------------------------
package cob_pkg;

  localparam int CursorMaxSideDef = 64;
  localparam int FrameMaxSide     = 4096;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OVERLAY_ENABLE = 3'd0,
    CFG_CURSOR_LEFT    = 3'd1,
    CFG_CURSOR_TOP     = 3'd2,
    CFG_CURSOR_WIDTH   = 3'd3,
    CFG_CURSOR_HEIGHT  = 3'd4
  } cob_cfg_idx_e;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

### rtl/core/cob_ram.sv
// ----------------------------------------------------------------------------
// Cursor overlay blend: generic RAM
// One write port and one read port with a registered read that holds while
// the read enable is low.
// ----------------------------------------------------------------------------
module cob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/cursor_overlay_blend.sv
// An accepted pixel item moves through stages 1, 2 and 3 into the output register.
// Throughput: one item per cycle unless the output stalls. The cursor store has one
// read and one write port; each item uses at most one of them when leaving stage 1.
// Reset clears every valid bit and the configuration registers (overlay off, zero
// rectangle); the cursor store is not cleared and holds nothing defined until loaded.
// ----------------------------------------------------------------------------
// Cursor overlay blend
// Blends a hardware cursor image, held in an on-chip store, over a BGRA pixel
// stream through a four-stage pipeline.
// ----------------------------------------------------------------------------
module cursor_overlay_blend
  import cob_pkg::*;
#(
  parameter int CURSOR_MAX_SIDE = CursorMaxSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [11:0]         pixel_x_i,
  input  logic [11:0]         pixel_y_i,
  input  logic [7:0]          in_blue_i,
  input  logic [7:0]          in_green_i,
  input  logic [7:0]          in_red_i,
  input  logic [7:0]          in_alpha_i,
  input  logic [5:0]          load_row_i,
  input  logic [5:0]          load_col_i,
  input  logic [31:0]         cursor_word_i,
  // Result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_blue_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_alpha_o
);

  `include "cursor_overlay_blend_macros.svh"

  localparam int Depth = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
  localparam int AddrW = $clog2(Depth);
  localparam int SideW = $clog2(CURSOR_MAX_SIDE);

  // --------------------------------------------------------------------------
  // Configuration registers; the port never stalls. Writes must only arrive while
  // the pipeline is empty (unchecked), so no item ever sees a half-updated rectangle.
  // --------------------------------------------------------------------------
  logic        cfg_enable_q;
  logic [12:0] cfg_left_q;
  logic [12:0] cfg_top_q;
  logic [6:0]  cfg_width_q;
  logic [6:0]  cfg_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_enable_q <= 1'b0;
      cfg_left_q   <= '0;
      cfg_top_q    <= '0;
      cfg_width_q  <= '0;
      cfg_height_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OVERLAY_ENABLE: cfg_enable_q <= cfg_data_i[0];
        CFG_CURSOR_LEFT:    cfg_left_q   <= cfg_data_i;
        CFG_CURSOR_TOP:     cfg_top_q    <= cfg_data_i;
        CFG_CURSOR_WIDTH:   cfg_width_q  <= cfg_data_i[6:0];
        CFG_CURSOR_HEIGHT:  cfg_height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves on when it is empty or when the
  // stage after it moves on, so a stalled output backs the whole pipe up
  // without losing or repeating an item.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4       = !v4_q || out_ready_i;
  assign adv3       = !v3_q || adv4;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // --------------------------------------------------------------------------
  // Stage 0 (combinational on the input): position the pixel against the
  // cursor rectangle and work out the cursor store address. Width and height
  // above the store's side are clipped to it. The offsets are 14-bit two's
  // complement, wide enough for any pixel coordinate minus any edge.
  // --------------------------------------------------------------------------
  logic [8:0]       w_eff, h_eff;
  logic [13:0]      dx, dy;
  logic             in_x, in_y, in_frame, hit;
  logic             load_ok;
  logic [AddrW-1:0] pix_addr, load_addr;

  always_comb begin
    w_eff = (32'(cfg_width_q) > 32'(CURSOR_MAX_SIDE)) ? 9'(CURSOR_MAX_SIDE)
                                                        : 9'(cfg_width_q);
    h_eff = (32'(cfg_height_q) > 32'(CURSOR_MAX_SIDE)) ? 9'(CURSOR_MAX_SIDE)
                                                         : 9'(cfg_height_q);
    dx = {2'b00, pixel_x_i} - {cfg_left_q[12], cfg_left_q};
    dy = {2'b00, pixel_y_i} - {cfg_top_q[12], cfg_top_q};
    in_x = !dx[13] && (dx[12:0] < 13'(w_eff));
    in_y = !dy[13] && (dy[12:0] < 13'(h_eff));
    in_frame = (32'(pixel_x_i) < 32'(FrameMaxSide)) &&
               (32'(pixel_y_i) < 32'(FrameMaxSide));
    hit = cfg_enable_q && in_frame && in_x && in_y;
    pix_addr = AddrW'(32'(dy[SideW-1:0]) * 32'(CURSOR_MAX_SIDE) +
                      32'(dx[SideW-1:0]));
    load_ok = (32'(load_row_i) < 32'(CURSOR_MAX_SIDE)) &&
              (32'(load_col_i) < 32'(CURSOR_MAX_SIDE));
    load_addr = AddrW'(32'(load_row_i) * 32'(CURSOR_MAX_SIDE) + 32'(load_col_i));
  end

  // --------------------------------------------------------------------------
  // Stage 1: the accepted item. A load writes the store as it leaves this
  // stage and goes no further; a covered pixel reads its cursor entry at the
  // same point. Doing both here keeps store accesses in item order, so a
  // pixel always sees every load that came before it.
  // --------------------------------------------------------------------------
  logic             s1_kind_q;
  logic             s1_hit_q;
  logic             s1_load_ok_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [31:0]      s1_word_q;
  logic [7:0]       s1_blue_q, s1_green_q, s1_red_q, s1_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_kind_q    <= kind_i;
      s1_hit_q     <= hit;
      s1_load_ok_q <= load_ok;
      s1_addr_q    <= (kind_i == KIND_LOAD) ? load_addr : pix_addr;
      s1_word_q    <= cursor_word_i;
      s1_blue_q    <= in_blue_i;
      s1_green_q   <= in_green_i;
      s1_red_q     <= in_red_i;
      s1_alpha_q   <= in_alpha_i;
    end
  end

  logic        ram_we, ram_re;
  logic [31:0] cur_word;

  assign ram_we = adv2 && v1_q && (s1_kind_q == KIND_LOAD) && s1_load_ok_q;
  assign ram_re = adv2 && v1_q && (s1_kind_q == KIND_PIXEL) && s1_hit_q;

  cob_ram #(
    .WIDTH (32),
    .DEPTH (Depth)
  ) u_cursor_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_word_q),
    .re_i    (ram_re),
    .raddr_i (s1_addr_q),
    .rdata_o (cur_word)
  );

  // --------------------------------------------------------------------------
  // Stage 2: pixels only, with the cursor entry in the store's read register.
  // The weighted products c*a and d*(255-a) are summed per channel here.
  // --------------------------------------------------------------------------
  logic       s2_hit_q;
  logic [7:0] s2_blue_q, s2_green_q, s2_red_q, s2_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q && (s1_kind_q == KIND_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_hit_q   <= s1_hit_q;
      s2_blue_q  <= s1_blue_q;
      s2_green_q <= s1_green_q;
      s2_red_q   <= s1_red_q;
      s2_alpha_q <= s1_alpha_q;
    end
  end

  logic [7:0]  cur_a, cur_b, cur_g, cur_r, inv_a;
  logic [15:0] sum_b, sum_g, sum_r;

  always_comb begin
    cur_a = cur_word[31:24];
    cur_r = cur_word[23:16];
    cur_g = cur_word[15:8];
    cur_b = cur_word[7:0];
    inv_a = 8'd255 - cur_a;
    sum_b = 16'(cur_b) * 16'(cur_a) + 16'(s2_blue_q)  * 16'(inv_a);
    sum_g = 16'(cur_g) * 16'(cur_a) + 16'(s2_green_q) * 16'(inv_a);
    sum_r = 16'(cur_r) * 16'(cur_a) + 16'(s2_red_q)   * 16'(inv_a);
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide the sums by 255 and choose between pass, replace and
  // blend. A transparent cursor entry leaves the pixel, alpha included.
  // --------------------------------------------------------------------------
  logic        s3_hit_q, s3_opaque_q, s3_clear_q;
  logic [15:0] s3_sum_b_q, s3_sum_g_q, s3_sum_r_q;
  logic [7:0]  s3_cur_b_q, s3_cur_g_q, s3_cur_r_q;
  logic [7:0]  s3_blue_q, s3_green_q, s3_red_q, s3_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_hit_q    <= s2_hit_q;
      s3_opaque_q <= (cur_a == ALPHA_OPAQUE);
      s3_clear_q  <= (cur_a == ALPHA_CLEAR);
      s3_sum_b_q  <= sum_b;
      s3_sum_g_q  <= sum_g;
      s3_sum_r_q  <= sum_r;
      s3_cur_b_q  <= cur_b;
      s3_cur_g_q  <= cur_g;
      s3_cur_r_q  <= cur_r;
      s3_blue_q   <= s2_blue_q;
      s3_green_q  <= s2_green_q;
      s3_red_q    <= s2_red_q;
      s3_alpha_q  <= s2_alpha_q;
    end
  end

  logic       s3_cover;
  logic [7:0] res_b, res_g, res_r, res_a;

  always_comb begin
    s3_cover = s3_hit_q && !s3_clear_q;
    res_b = s3_blue_q;
    res_g = s3_green_q;
    res_r = s3_red_q;
    res_a = s3_alpha_q;
    if (s3_cover) begin
      res_a = ALPHA_OPAQUE;
      if (s3_opaque_q) begin
        res_b = s3_cur_b_q;
        res_g = s3_cur_g_q;
        res_r = s3_cur_r_q;
      end else begin
        res_b = div255(s3_sum_b_q);
        res_g = div255(s3_sum_g_q);
        res_r = div255(s3_sum_r_q);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: output register. It holds its item until the consumer takes it.
  // --------------------------------------------------------------------------
  logic [7:0] out_b_q, out_g_q, out_r_q, out_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      out_b_q <= res_b;
      out_g_q <= res_g;
      out_r_q <= res_r;
      out_a_q <= res_a;
    end
  end

  assign out_valid_o = v4_q;
  assign out_blue_o  = out_b_q;
  assign out_green_o = out_g_q;
  assign out_red_o   = out_r_q;
  assign out_alpha_o = out_a_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `COB_ASSERT_IMP(a_store_one_access, ram_we, !ram_re, "store written and read at once")
  `COB_ASSERT_NXT(a_load_no_result, v1_q && (s1_kind_q == KIND_LOAD) && adv2, !v2_q, "load item reached blend stage")
  `COB_ASSERT_NXT(a_pass_keeps_alpha, v3_q && !s3_cover && adv4, out_alpha_o == $past(s3_alpha_q), "uncovered pixel alpha changed")
  `COB_ASSERT_NXT(a_cover_opaque, v3_q && s3_cover && adv4, out_alpha_o == ALPHA_OPAQUE, "covered pixel alpha not opaque")

endmodule

### tb/sv/cursor_overlay_blend_tb.sv
// ----------------------------------------------------------------------------
// Cursor overlay blend testbench
// Drives a directed table, then random loads and pixels, through the block
// under several rectangle settings and handshake idling patterns, and checks
// every result pixel against a typed value or a cursor-tracking predictor.
// ----------------------------------------------------------------------------
module cursor_overlay_blend_tb
  import cob_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Side = CursorMaxSideDef;

  // One BGRA pixel, blue first, so that a literal reads as 32'hBBGGRRAA.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } bgra_t;

  // One input item with every field, whether or not its kind uses it.
  typedef struct packed {
    logic        kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    bgra_t       colour;
    logic [5:0]  load_row;
    logic [5:0]  load_col;
    logic [31:0] cursor_word;
  } stim_item_t;

  // The overlay registers, held as raw register bits.
  typedef struct packed {
    logic        enable;
    logic [12:0] left;
    logic [12:0] top;
    logic [6:0]  width;
    logic [6:0]  height;
  } cursor_cfg_t;

  // A row of the directed table either reprograms the overlay or sends an item.
  // Where typed is set, want holds the expected pixel written out by hand.
  typedef struct packed {
    logic        reprogram;
    cursor_cfg_t cfg;
    stim_item_t  item;
    logic        typed;
    bgra_t       want;
  } directed_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  logic [11:0]         pixel_x_i;
  logic [11:0]         pixel_y_i;
  logic [7:0]          in_blue_i;
  logic [7:0]          in_green_i;
  logic [7:0]          in_red_i;
  logic [7:0]          in_alpha_i;
  logic [5:0]          load_row_i;
  logic [5:0]          load_col_i;
  logic [31:0]         cursor_word_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          out_blue_o;
  logic [7:0]          out_green_o;
  logic [7:0]          out_red_o;
  logic [7:0]          out_alpha_o;

  // Shadow of the overlay registers, updated as each register write is taken.
  logic              sh_enable = 1'b0;
  logic signed [12:0] sh_left  = '0;
  logic signed [12:0] sh_top   = '0;
  logic [6:0]        sh_width  = '0;
  logic [6:0]        sh_height = '0;

  // Shadow of the cursor store, with a flag per entry telling whether it has
  // been loaded since reset. An unloaded entry must never be read.
  logic [31:0] cursor_img [Side*Side];
  bit          loaded     [Side*Side];

  // Result pixels still owed by the block, oldest first.
  bgra_t pending_pixels[$];

  // Directed stimulus, walked in order once reset is released.
  directed_row_t dir_table[$];

  int fail_count      = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  cursor_overlay_blend dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .in_blue_i     (in_blue_i),
    .in_green_i    (in_green_i),
    .in_red_i      (in_red_i),
    .in_alpha_i    (in_alpha_i),
    .load_row_i    (load_row_i),
    .load_col_i    (load_col_i),
    .cursor_word_i (cursor_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_blue_o    (out_blue_o),
    .out_green_o   (out_green_o),
    .out_red_o     (out_red_o),
    .out_alpha_o   (out_alpha_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A generous ceiling: the slowest legal run needs well under a tenth of it.
  initial begin
    #5ms;
    $display("cursor_overlay_blend verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Cursor store entry under a frame pixel, or -1 when the pixel lies outside
  // the enabled rectangle. Width and height above the store side saturate.
  function automatic int cursor_slot(logic [11:0] px, logic [11:0] py);
    int dx, dy, w, h;
    w  = (sh_width > Side) ? Side : int'(sh_width);
    h  = (sh_height > Side) ? Side : int'(sh_height);
    dx = int'(px) - int'(sh_left);
    dy = int'(py) - int'(sh_top);
    if (sh_enable && dx >= 0 && dy >= 0 && dx < w && dy < h) begin
      return dy * Side + dx;
    end
    return -1;
  endfunction

  // Weighted mean of cursor colour c and frame colour d, truncated.
  function automatic logic [7:0] mix_channel(int c, int d, int a);
    return 8'((c * a + d * (255 - a)) / 255);
  endfunction

  // Works out the pixel that leaves the block for a pixel item.
  function automatic bgra_t blend_pixel(stim_item_t it);
    bgra_t       res;
    int          slot;
    logic [31:0] cw;
    int          a;
    res  = it.colour;
    slot = cursor_slot(it.pixel_x, it.pixel_y);
    if (slot >= 0) begin
      cw = cursor_img[slot];
      a  = int'(cw[31:24]);
      if (cw[31:24] == ALPHA_OPAQUE) begin
        res = {cw[7:0], cw[15:8], cw[23:16], ALPHA_OPAQUE};
      end else if (cw[31:24] != ALPHA_CLEAR) begin
        res.blue  = mix_channel(cw[7:0], it.colour.blue, a);
        res.green = mix_channel(cw[15:8], it.colour.green, a);
        res.red   = mix_channel(cw[23:16], it.colour.red, a);
        res.alpha = ALPHA_OPAQUE;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  // The receiver stalls at the rate that the current phase asks for.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    bgra_t got;
    bgra_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {out_blue_o, out_green_o, out_red_o, out_alpha_o};
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result pixel %h arrived with nothing pending", got);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (got.blue !== want.blue || got.green !== want.green ||
            got.red !== want.red || got.alpha !== want.alpha) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("pixel mismatch: expected b=%h g=%h r=%h a=%h, got b=%h g=%h r=%h a=%h",
                     want.blue, want.green, want.red, want.alpha,
                     got.blue, got.green, got.red, got.alpha);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_item_t pixel_item(logic [11:0] x, logic [11:0] y, bgra_t c);
    stim_item_t it;
    it         = '0;
    it.kind    = KIND_PIXEL;
    it.pixel_x = x;
    it.pixel_y = y;
    it.colour  = c;
    return it;
  endfunction

  function automatic directed_row_t row_px(logic [11:0] x, logic [11:0] y, bgra_t c,
                                           logic typed, bgra_t want);
    directed_row_t r;
    r       = '0;
    r.item  = pixel_item(x, y, c);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic directed_row_t row_ld(logic [5:0] row, logic [5:0] col,
                                           logic [31:0] word);
    directed_row_t r;
    r                  = '0;
    r.item.kind        = KIND_LOAD;
    r.item.load_row    = row;
    r.item.load_col    = col;
    r.item.cursor_word = word;
    return r;
  endfunction

  function automatic directed_row_t row_cfg(logic en, logic [12:0] left, logic [12:0] top,
                                            logic [6:0] w, logic [6:0] h);
    directed_row_t r;
    r           = '0;
    r.reprogram = 1'b1;
    r.cfg       = '{enable: en, left: left, top: top, width: w, height: h};
    return r;
  endfunction

  // Appends one row to the end of the directed table.
  function automatic void add_row(directed_row_t r);
    dir_table.insert(dir_table.size(), r);
  endfunction

  // Cursor words lean on the two alpha extremes as often as on partial alpha.
  function automatic logic [31:0] random_cursor_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(3))
      0:       w[31:24] = ALPHA_CLEAR;
      1:       w[31:24] = ALPHA_OPAQUE;
      default: ;
    endcase
    return w;
  endfunction

  // Rectangle edges: mostly on the frame, some just off its top left, some
  // hugging its far edge, and some anywhere in the register's range.
  function automatic logic [12:0] random_edge();
    case ($urandom_range(5))
      0:       return 13'($urandom);
      1:       return 13'(-$urandom_range(1, 64));
      2:       return 13'($urandom_range(4032, 4095));
      default: return 13'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [6:0] random_extent();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'(Side);
      2:       return 7'($urandom_range(Side + 1, 127));
      default: return 7'($urandom_range(1, Side));
    endcase
  endfunction

  // A coordinate a few pixels either side of the rectangle's span, so that
  // most pixels land on the cursor or on its border.
  function automatic logic [11:0] near_coord(logic signed [12:0] origin, logic [6:0] extent);
    int span, v;
    span = (extent > Side) ? Side : int'(extent);
    v    = int'(origin) + int'($urandom_range(0, span + 7)) - 4;
    if (v < 0 || v > 4095) begin
      v = $urandom_range(0, 4095);
    end
    return 12'(v);
  endfunction

  // Sends one item and, once the block has taken it, updates the shadow store
  // or queues the pixel it owes.
  task automatic put_item(stim_item_t it, logic typed, bgra_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    pixel_x_i     <= it.pixel_x;
    pixel_y_i     <= it.pixel_y;
    in_blue_i     <= it.colour.blue;
    in_green_i    <= it.colour.green;
    in_red_i      <= it.colour.red;
    in_alpha_i    <= it.colour.alpha;
    load_row_i    <= it.load_row;
    load_col_i    <= it.load_col;
    cursor_word_i <= it.cursor_word;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.kind == KIND_LOAD) begin
      cursor_img[int'(it.load_row) * Side + int'(it.load_col)] = it.cursor_word;
      loaded[int'(it.load_row) * Side + int'(it.load_col)]     = 1'b1;
    end else begin
      pending_pixels.insert(pending_pixels.size(), typed ? want : blend_pixel(it));
    end
  endtask

  // A pixel that would read a cursor entry never loaded is preceded by a load
  // of that entry, so the store is never read before it is written.
  task automatic issue(stim_item_t it, logic typed, bgra_t want);
    stim_item_t fill;
    int         slot;
    slot = (it.kind == KIND_PIXEL) ? cursor_slot(it.pixel_x, it.pixel_y) : -1;
    if (slot >= 0 && !loaded[slot]) begin
      fill             = it;
      fill.kind        = KIND_LOAD;
      fill.load_row    = 6'(slot / Side);
      fill.load_col    = 6'(slot % Side);
      fill.cursor_word = random_cursor_word();
      put_item(fill, 1'b0, '0);
    end
    put_item(it, typed, want);
  endtask

  // Drops the input valid and waits until every owed pixel is out. Loads owe
  // nothing, so a few more cycles cover one still in the pipeline.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(cob_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_OVERLAY_ENABLE: sh_enable = data[0];
      CFG_CURSOR_LEFT:    sh_left   = data;
      CFG_CURSOR_TOP:     sh_top    = data;
      CFG_CURSOR_WIDTH:   sh_width  = data[6:0];
      CFG_CURSOR_HEIGHT:  sh_height = data[6:0];
      default: ;
    endcase
  endtask

  // Rewrites all five overlay registers while the block is idle. The valid
  // stays high across the writes and drops after the last one is taken.
  task automatic program_overlay(cursor_cfg_t c);
    wait_quiet();
    cfg_write(CFG_OVERLAY_ENABLE, CfgDataW'(c.enable));
    cfg_write(CFG_CURSOR_LEFT, c.left);
    cfg_write(CFG_CURSOR_TOP, c.top);
    cfg_write(CFG_CURSOR_WIDTH, CfgDataW'(c.width));
    cfg_write(CFG_CURSOR_HEIGHT, CfgDataW'(c.height));
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : stimulus
    stim_item_t    it;
    cursor_cfg_t   cfg;
    int            idle_plan[4];
    int            stall_plan[4];

    idle_plan  = '{0, 66, 0, 27};
    stall_plan = '{0, 0, 66, 27};

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_OVERLAY_ENABLE;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_PIXEL;
    pixel_x_i     <= '0;
    pixel_y_i     <= '0;
    in_blue_i     <= '0;
    in_green_i    <= '0;
    in_red_i      <= '0;
    in_alpha_i    <= '0;
    load_row_i    <= '0;
    load_col_i    <= '0;
    cursor_word_i <= '0;

    // With the reset settings the overlay is off, so both corner pixels of
    // the frame pass untouched, and loads leave no trace at the output.
    add_row(row_px(12'd0, 12'd0, 32'h00000000, 1'b1, 32'h00000000));
    add_row(row_px(12'd4095, 12'd4095, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF));
    add_row(row_ld(6'd0, 6'd0, 32'hFF112233));
    add_row(row_ld(6'd0, 6'd1, 32'h00AABBCC));
    add_row(row_ld(6'd1, 6'd0, 32'h80FF0000));
    add_row(row_ld(6'd63, 6'd63, 32'hFFFFFFFF));
    add_row(row_ld(6'd0, 6'd63, 32'h01000000));
    add_row(row_ld(6'd1, 6'd1, 32'hFE00FF80));
    add_row(row_px(12'd0, 12'd0, 32'h10203040, 1'b1, 32'h10203040));
    // Full-size cursor at the frame origin: opaque, clear, half, and the
    // alpha values one step in from each extreme.
    add_row(row_cfg(1'b1, 13'd0, 13'd0, 7'd64, 7'd64));
    add_row(row_px(12'd0, 12'd0, 32'h10203040, 1'b1, 32'h332211FF));
    add_row(row_px(12'd1, 12'd0, 32'h10203040, 1'b1, 32'h10203040));
    add_row(row_px(12'd0, 12'd1, 32'h00000007, 1'b1, 32'h000080FF));
    add_row(row_px(12'd63, 12'd63, 32'h00000000, 1'b1, 32'hFFFFFFFF));
    add_row(row_px(12'd63, 12'd0, 32'hFFFFFF00, 1'b0, '0));
    add_row(row_px(12'd1, 12'd1, 32'h12345678, 1'b0, '0));
    add_row(row_px(12'd64, 12'd0, 32'h0A0B0C0D, 1'b1, 32'h0A0B0C0D));
    // An oversized rectangle is clipped to the store side.
    add_row(row_cfg(1'b1, 13'd0, 13'd0, 7'd127, 7'd127));
    add_row(row_px(12'd64, 12'd63, 32'h01020304, 1'b1, 32'h01020304));
    add_row(row_px(12'd63, 12'd63, 32'h01020304, 1'b1, 32'hFFFFFFFF));
    // Rectangle at the most negative edge: nothing on the frame is covered.
    add_row(row_cfg(1'b1, 13'h1000, 13'h1000, 7'd64, 7'd64));
    add_row(row_px(12'd0, 12'd0, 32'hAA55AA55, 1'b1, 32'hAA55AA55));
    // Rectangle at the far corner: only the last frame pixel is covered.
    add_row(row_cfg(1'b1, 13'h0FFF, 13'h0FFF, 7'd64, 7'd64));
    add_row(row_px(12'd4095, 12'd4095, 32'h00000000, 1'b1, 32'h332211FF));
    add_row(row_px(12'd4094, 12'd4095, 32'h0A0B0C0D, 1'b1, 32'h0A0B0C0D));
    // Rectangle hanging off the top left by one pixel.
    add_row(row_cfg(1'b1, 13'h1FFF, 13'h1FFF, 7'd2, 7'd2));
    add_row(row_px(12'd0, 12'd0, 32'hC0C0C0C0, 1'b0, '0));
    add_row(row_px(12'd1, 12'd0, 32'h11111111, 1'b1, 32'h11111111));
    // A zero-width rectangle covers nothing.
    add_row(row_cfg(1'b1, 13'd0, 13'd0, 7'd0, 7'd64));
    add_row(row_px(12'd0, 12'd0, 32'h55AA55AA, 1'b1, 32'h55AA55AA));
    // Overlay switched off over a loaded, full-size rectangle.
    add_row(row_cfg(1'b0, 13'd0, 13'd0, 7'd64, 7'd64));
    add_row(row_px(12'd0, 12'd0, 32'h01020304, 1'b1, 32'h01020304));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[k]) begin
      if (dir_table[k].reprogram) begin
        program_overlay(dir_table[k].cfg);
      end else begin
        issue(dir_table[k].item, dir_table[k].typed, dir_table[k].want);
      end
    end

    // Random part: four idling phases, each run under five random overlay
    // settings. Most pixels fall on or around the rectangle; the rest roam
    // the whole frame so that every coordinate bit toggles.
    for (int ph = 0; ph < 4; ph++) begin
      for (int seg = 0; seg < 5; seg++) begin
        cfg.enable = ($urandom_range(9) != 0);
        cfg.left   = random_edge();
        cfg.top    = random_edge();
        cfg.width  = random_extent();
        cfg.height = random_extent();
        program_overlay(cfg);
        sender_idle_pct = idle_plan[ph];
        recv_stall_pct  = stall_plan[ph];
        for (int n = 0; n < 55; n++) begin
          it.kind        = ($urandom_range(99) < 15) ? KIND_LOAD : KIND_PIXEL;
          it.pixel_x     = 12'($urandom);
          it.pixel_y     = 12'($urandom);
          it.colour      = $urandom;
          it.load_row    = 6'($urandom);
          it.load_col    = 6'($urandom);
          it.cursor_word = random_cursor_word();
          if (it.kind == KIND_PIXEL && $urandom_range(3) != 0) begin
            it.pixel_x = near_coord(sh_left, sh_width);
            it.pixel_y = near_coord(sh_top, sh_height);
          end
          issue(it, 1'b0, '0);
        end
      end
    end

    wait_quiet();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("cursor_overlay_blend verification clean");
    end else begin
      $display("cursor_overlay_blend verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/cob_pkg.sv
rtl/core/cob_ram.sv
rtl/core/cursor_overlay_blend.sv
tb/sv/cursor_overlay_blend_tb.sv
